@@ sv/bbp_pkg.sv @@
// Shared constants, types and helper functions of the Bezier patch evaluator.
`default_nettype none

package bbp_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int PARAM_FRAC_BITS = 16;

    localparam int NUM_PTS = 16;
    localparam int PT_AW   = $clog2(NUM_PTS);
    localparam int PT_W    = 3 * COORD_WIDTH;

    // weight and product widths
    localparam int WT_W   = PARAM_FRAC_BITS + 1;
    localparam int TRI_W  = WT_W + 1;
    localparam int P1_W   = TRI_W + WT_W;
    localparam int P2_W   = P1_W + WT_W;
    localparam int RND_SH = 2 * PARAM_FRAC_BITS;
    localparam int PP_W   = WT_W + 1 + COORD_WIDTH;
    localparam int ROW_W  = PP_W + 2;
    localparam int TERM_W = ROW_W + WT_W + 1;
    localparam int ACC_W  = TERM_W + 2;
    localparam int SH_W   = ACC_W - RND_SH;

    // stream field offsets, lowest bit first
    localparam int OFF_ROW = 0;
    localparam int OFF_COL = 2;
    localparam int OFF_X   = 4;
    localparam int OFF_Y   = OFF_X + COORD_WIDTH;
    localparam int OFF_Z   = OFF_Y + COORD_WIDTH;
    localparam int OFF_U   = OFF_Z + COORD_WIDTH;
    localparam int OFF_V   = OFF_U + WT_W;
    localparam int IN_USED = OFF_V + WT_W;
    localparam int IN_DW   = ((IN_USED + 7) / 8) * 8;
    localparam int OUT_DW  = ((PT_W + 7) / 8) * 8;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    localparam logic [WT_W-1:0]   PONE     = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
    localparam logic [P2_W-1:0]   WT_HALF  = P2_W'(1) << (RND_SH - 1);
    localparam logic [ACC_W-1:0]  ACC_HALF = ACC_W'(1) << (RND_SH - 1);
    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [SH_W-1:0] SAT_MAX  = SH_W'($signed(COORD_MAX));
    localparam logic signed [SH_W-1:0] SAT_MIN  = SH_W'($signed(COORD_MIN));

    typedef struct packed {
        logic             ld;
        logic             latch;
        logic             wt_go;
        logic [2:0]       wt_k;
        logic             rd_go;
        logic [PT_AW-1:0] rd_addr;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_status;

    function automatic logic [WT_W-1:0] clamp_param(input logic [WT_W-1:0] p);
        return (p > PONE) ? PONE : p;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] r;
        logic signed [SH_W-1:0]  sh;
        r  = a + $signed(ACC_HALF);
        sh = $signed(r[ACC_W-1:RND_SH]);
        if (sh > SAT_MAX)
            return COORD_MAX;
        else if (sh < SAT_MIN)
            return COORD_MIN;
        return sh[COORD_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/bicubic_bezier_patch_eval.sv @@
// Bicubic Bezier patch evaluator: top level joining sequencer and datapath.
//
// Input stream s_axis carries one request per transfer. tuser selects the kind:
// a load writes one control point (x, y, z in signed Q7.8) into a 4x4 point
// store, an evaluate brings u and v in Q1.16 (values above one are clamped).
// Output stream m_axis returns one patch point per evaluate, none per load.
// Loads are taken one per cycle while the sequencer idles. An evaluate runs
// eight weight steps on a two-multiplier Bernstein unit, then sweeps the
// sixteen points of the store one read per cycle through three MAC lanes;
// no further request is taken until the sum has left the accumulator, so
// evaluate throughput is set by the weight steps, the single read port of
// the point store and the lane pipeline.
// The result register parts the two sides: a new request is taken while a
// result waits. A stalled receiver holds m_axis_tvalid and data; a second
// result then waits in the accumulator and s_axis_tready stays low.
// Synchronous active-low reset clears the sequencer and all valid flags; the
// point store is not cleared and all 16 points must be loaded before use.
`default_nettype none

module bicubic_bezier_patch_eval import bbp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // point_row, point_col, ctrl_x, ctrl_y, ctrl_z, u_coord, v_coord, zero fill
    input  wire logic [IN_DW-1:0]  s_axis_tdata,
    // req_type
    input  wire logic              s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // surf_x, surf_y, surf_z
    output logic [OUT_DW-1:0]      m_axis_tdata
);

    t_cmd            cmd;
    t_status         status;
    logic [PT_W-1:0] out_data;

    bbp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_type   (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .o_cmd    (cmd),
        .i_status (status)
    );

    bbp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_point_row (s_axis_tdata[OFF_ROW +: 2]),
        .i_point_col (s_axis_tdata[OFF_COL +: 2]),
        .i_point     (s_axis_tdata[OFF_X +: PT_W]),
        .i_u_coord   (s_axis_tdata[OFF_U +: WT_W]),
        .i_v_coord   (s_axis_tdata[OFF_V +: WT_W]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (out_data)
    );

    assign m_axis_tdata = OUT_DW'(out_data);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_go |-> !cmd.wt_go)
        else $error("weight step and store read issued together");

    a_eval_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
        else $error("request taken during an evaluate");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.busy |-> !s_axis_tready)
        else $error("ready while datapath busy");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(status.busy))
        else $error("result without a finished sum");

endmodule

`default_nettype wire

@@ sv/bbp_ram.sv @@
// Generic single-port-write RAM with registered read.
`default_nettype none

module bbp_ram #(
    parameter  int WIDTH = 48,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/bbp_ctrl.sv @@
// Sequencer: weight steps, point-store sweep and drain of the datapath.
`default_nettype none

module bbp_ctrl import bbp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire logic    i_type,
    output logic         o_ready,
    output t_cmd         o_cmd,
    input  wire t_status i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_SUM,
        ST_DRAIN
    } t_state;

    t_state           r_state;
    logic [PT_AW:0]   r_cnt;
    logic             r_wt_go;
    logic [2:0]       r_wt_k;
    logic             r_rd_go;
    logic [PT_AW-1:0] r_rd_addr;
    logic             accept;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_cmd.ld      = accept && (i_type == REQ_LOAD);
        o_cmd.latch   = accept && (i_type == REQ_EVAL);
        o_cmd.wt_go   = r_wt_go;
        o_cmd.wt_k    = r_wt_k;
        o_cmd.rd_go   = r_rd_go;
        o_cmd.rd_addr = r_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_wt_go   <= 1'b0;
            r_wt_k    <= '0;
            r_rd_go   <= 1'b0;
            r_rd_addr <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept && (i_type == REQ_EVAL)) begin
                        r_state <= ST_WEIGHT;
                        r_wt_go <= 1'b1;
                        r_wt_k  <= '0;
                        r_cnt   <= (PT_AW+1)'(1);
                    end
                end
                ST_WEIGHT: begin
                    if (r_cnt == (PT_AW+1)'(8)) begin
                        r_wt_go   <= 1'b0;
                        r_rd_go   <= 1'b1;
                        r_rd_addr <= '0;
                        r_cnt     <= (PT_AW+1)'(1);
                        r_state   <= ST_SUM;
                    end else begin
                        r_wt_k <= r_cnt[2:0];
                        r_cnt  <= r_cnt + 1'b1;
                    end
                end
                ST_SUM: begin
                    if (r_cnt == (PT_AW+1)'(NUM_PTS)) begin
                        r_rd_go <= 1'b0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_rd_addr <= r_cnt[PT_AW-1:0];
                        r_cnt     <= r_cnt + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (!i_status.busy) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/bbp_datapath.sv @@
// Datapath: Bernstein weights, point store, per-axis MAC lanes and result register.
`default_nettype none

module bbp_datapath import bbp_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    output t_status                     o_status,
    input  wire logic [1:0]             i_point_row,
    input  wire logic [1:0]             i_point_col,
    input  wire logic [PT_W-1:0]        i_point,
    input  wire logic [WT_W-1:0]        i_u_coord,
    input  wire logic [WT_W-1:0]        i_v_coord,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [PT_W-1:0]             o_out_data
);

    // parameters, clamped to one
    logic [WT_W-1:0] r_u;
    logic [WT_W-1:0] r_v;

    // weight unit
    logic [WT_W-1:0]  wt_t;
    logic [WT_W-1:0]  wt_s;
    logic [TRI_W-1:0] wt_tri;
    logic [TRI_W-1:0] wt_a;
    logic [WT_W-1:0]  wt_b;
    logic [WT_W-1:0]  wt_c;
    logic [P1_W-1:0]  wt_p1;
    logic [P2_W-1:0]  wt_p2;
    logic [P2_W-1:0]  wt_rnd;
    logic [P1_W-1:0]  r_wa;
    logic [WT_W-1:0]  r_wc;
    logic             r_wa_v;
    logic             r_wa_isv;
    logic [WT_W-1:0]  r_wu [4];
    logic [WT_W-1:0]  r_wv [4];

    // point store
    logic [PT_W-1:0]  rd_data;
    logic             r_rd_v;
    logic [PT_AW-1:0] r_rd_addr;

    // lanes
    logic signed [PP_W-1:0]   pp [3];
    logic signed [PP_W-1:0]   r_pp [3];
    logic                     r_pp_v;
    logic                     r_pp_first;
    logic                     r_pp_last;
    logic                     r_pp_row0;
    logic                     r_pp_row3;
    logic signed [ROW_W-1:0]  r_row [3];
    logic                     r_row_done;
    logic                     r_row_first;
    logic                     r_row_fin;
    logic signed [TERM_W-1:0] r_term [3];
    logic                     r_term_v;
    logic                     r_term_first;
    logic                     r_term_fin;
    logic signed [ACC_W-1:0]  r_acc [3];
    logic                     r_acc_done;
    logic [COORD_WIDTH-1:0]   r_out [3];
    logic                     r_out_v;
    logic                     out_load;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_u <= clamp_param(i_u_coord);
            r_v <= clamp_param(i_v_coord);
        end
    end

    // weight step k: bit 2 picks v, bits 1:0 pick the Bernstein term
    always_comb begin
        wt_t   = i_cmd.wt_k[2] ? r_v : r_u;
        wt_s   = PONE - wt_t;
        wt_tri = {wt_t, 1'b0} + TRI_W'(wt_t);
        case (i_cmd.wt_k[1:0])
            2'd0:    begin wt_a = TRI_W'(wt_s); wt_b = wt_s; wt_c = wt_s; end
            2'd1:    begin wt_a = wt_tri;       wt_b = wt_s; wt_c = wt_s; end
            2'd2:    begin wt_a = wt_tri;       wt_b = wt_t; wt_c = wt_s; end
            default: begin wt_a = TRI_W'(wt_t); wt_b = wt_t; wt_c = wt_t; end
        endcase
        wt_p1  = P1_W'(wt_a) * P1_W'(wt_b);
        wt_p2  = P2_W'(r_wa) * P2_W'(r_wc);
        wt_rnd = wt_p2 + WT_HALF;
    end

    always_ff @(posedge i_clk) begin
        r_wa     <= wt_p1;
        r_wc     <= wt_c;
        r_wa_isv <= i_cmd.wt_k[2];
        if (r_wa_v && !r_wa_isv) begin
            r_wu[0] <= r_wu[1];
            r_wu[1] <= r_wu[2];
            r_wu[2] <= r_wu[3];
            r_wu[3] <= wt_rnd[RND_SH +: WT_W];
        end else if (r_row_done) begin
            r_wu[0] <= r_wu[1];
            r_wu[1] <= r_wu[2];
            r_wu[2] <= r_wu[3];
            r_wu[3] <= r_wu[0];
        end
        if (r_wa_v && r_wa_isv) begin
            r_wv[0] <= r_wv[1];
            r_wv[1] <= r_wv[2];
            r_wv[2] <= r_wv[3];
            r_wv[3] <= wt_rnd[RND_SH +: WT_W];
        end else if (r_rd_v) begin
            r_wv[0] <= r_wv[1];
            r_wv[1] <= r_wv[2];
            r_wv[2] <= r_wv[3];
            r_wv[3] <= r_wv[0];
        end
    end

    bbp_ram #(
        .WIDTH (PT_W),
        .DEPTH (NUM_PTS)
    ) u_pts (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld),
        .i_waddr ({i_point_row, i_point_col}),
        .i_wdata (i_point),
        .i_re    (i_cmd.rd_go),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pp[k] = $signed({1'b0, r_wv[0]})
                  * $signed(rd_data[k*COORD_WIDTH +: COORD_WIDTH]);
        end
    end

    assign out_load = r_acc_done && (!r_out_v || i_out_ready);

    // lane registers
    always_ff @(posedge i_clk) begin
        r_rd_addr <= i_cmd.rd_addr;
        if (r_rd_v) begin
            r_pp_first <= (r_rd_addr[1:0] == 2'd0);
            r_pp_last  <= (r_rd_addr[1:0] == 2'd3);
            r_pp_row0  <= (r_rd_addr[PT_AW-1:2] == 2'd0);
            r_pp_row3  <= (r_rd_addr[PT_AW-1:2] == 2'd3);
        end
        if (r_pp_v && r_pp_last) begin
            r_row_first <= r_pp_row0;
            r_row_fin   <= r_pp_row3;
        end
        if (r_row_done) begin
            r_term_first <= r_row_first;
            r_term_fin   <= r_row_fin;
        end
        for (int k = 0; k < 3; k++) begin
            if (r_rd_v) begin
                r_pp[k] <= pp[k];
            end
            if (r_pp_v) begin
                r_row[k] <= r_pp_first ? ROW_W'(r_pp[k]) : r_row[k] + ROW_W'(r_pp[k]);
            end
            if (r_row_done) begin
                r_term[k] <= $signed(r_row[k]) * $signed({1'b0, r_wu[0]});
            end
            if (r_term_v) begin
                r_acc[k] <= r_term_first ? ACC_W'(r_term[k])
                                         : r_acc[k] + ACC_W'(r_term[k]);
            end
            if (out_load) begin
                r_out[k] <= round_sat(r_acc[k]);
            end
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa_v     <= 1'b0;
            r_rd_v     <= 1'b0;
            r_pp_v     <= 1'b0;
            r_row_done <= 1'b0;
            r_term_v   <= 1'b0;
            r_acc_done <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_wa_v     <= i_cmd.wt_go;
            r_rd_v     <= i_cmd.rd_go;
            r_pp_v     <= r_rd_v;
            r_row_done <= r_pp_v && r_pp_last;
            r_term_v   <= r_row_done;
            if (r_term_v && r_term_fin) begin
                r_acc_done <= 1'b1;
            end else if (out_load) begin
                r_acc_done <= 1'b0;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_status.busy = r_rd_v || r_pp_v || r_row_done || r_term_v || r_acc_done;
    assign o_out_valid   = r_out_v;
    assign o_out_data    = {r_out[2], r_out[1], r_out[0]};

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the bicubic Bezier patch evaluator: point loads, patch evaluates.
`timescale 1ns / 1ps

module tb import bbp_pkg::*; ();

    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    typedef logic [WT_W-1:0] t_weights [4];
    typedef logic [2:0][COORD_WIDTH-1:0] t_surf;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_DW-1:0]    s_axis_tdata = '0;
    logic                s_axis_tuser = REQ_LOAD;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]   m_axis_tdata;

    logic signed [COORD_WIDTH-1:0] ctrl_store [16][3];
    t_surf patch_expected_q [$];
    int    fail_count = 0;
    int    idle_cycles = 0;
    int    ready_hold = 0;
    int    hold_draw = 0;
    bit    no_gaps = 1'b0;
    string axis_name [3] = '{"surf_x", "surf_y", "surf_z"};

    bicubic_bezier_patch_eval i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // point_row, point_col, ctrl_x/y/z, u, v, zero fill
        .s_axis_tuser  (s_axis_tuser),   // req_type
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // surf_x, surf_y, surf_z
    );

    always #6 i_clk = ~i_clk;

    // one Bernstein weight: a*b*c / 2^(2F), rounded half-up
    function automatic logic [WT_W-1:0] round_weight(input longint unsigned a, b, c);
        longint unsigned p;
        p = a * b * c + (64'd1 << (2 * PARAM_FRAC_BITS - 1));
        return WT_W'(p >> (2 * PARAM_FRAC_BITS));
    endfunction

    function automatic t_weights bernstein_weights(input logic [WT_W-1:0] raw);
        t_weights w;
        longint unsigned t, s;
        t = (raw > PONE) ? longint'(PONE) : longint'(raw);
        s = longint'(PONE) - t;
        w[0] = round_weight(s, s, s);
        w[1] = round_weight(3 * t, s, s);
        w[2] = round_weight(3 * t, t, s);
        w[3] = round_weight(t, t, t);
        return w;
    endfunction

    function automatic t_surf patch_point(input logic [WT_W-1:0] u, v);
        t_weights wu, wv;
        longint   acc, row;
        t_surf    r;
        wu = bernstein_weights(u);
        wv = bernstein_weights(v);
        for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int i = 0; i < 4; i++) begin
                row = 0;
                for (int j = 0; j < 4; j++)
                    row += longint'(wv[j]) * longint'(ctrl_store[i*4+j][k]);
                acc += row * longint'(wu[i]);
            end
            acc = (acc + (64'sd1 <<< (2 * PARAM_FRAC_BITS - 1))) >>> (2 * PARAM_FRAC_BITS);
            if (acc > longint'($signed(COORD_MAX)))
                r[k] = COORD_MAX;
            else if (acc < longint'($signed(COORD_MIN)))
                r[k] = COORD_MIN;
            else
                r[k] = acc[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [WT_W-1:0] rand_param();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return PONE;
            2: return WT_W'($urandom_range(int'(PONE) + 1, (1 << WT_W) - 1));
            default: return WT_W'($urandom_range(0, int'(PONE) - 1));
        endcase
    endfunction

    // one request; the model state moves on at acceptance
    task automatic send_request(input logic kind, input logic [1:0] row, col,
                                input logic [COORD_WIDTH-1:0] x, y, z,
                                input logic [WT_W-1:0] u, v);
        int gap;
        logic [IN_DW-1:0] data;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        data = '0;
        data[OFF_ROW +: 2] = row;
        data[OFF_COL +: 2] = col;
        data[OFF_X +: COORD_WIDTH] = x;
        data[OFF_Y +: COORD_WIDTH] = y;
        data[OFF_Z +: COORD_WIDTH] = z;
        data[OFF_U +: WT_W] = u;
        data[OFF_V +: WT_W] = v;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (kind == REQ_LOAD) begin
            ctrl_store[{row, col}][0] = x;
            ctrl_store[{row, col}][1] = y;
            ctrl_store[{row, col}][2] = z;
        end else begin
            patch_expected_q.push_back(patch_point(u, v));
        end
    endtask

    task automatic load_point(input int idx, input logic [COORD_WIDTH-1:0] x, y, z);
        send_request(REQ_LOAD, 2'(idx >> 2), 2'(idx), x, y, z, rand_param(), rand_param());
    endtask

    task automatic evaluate_at(input logic [WT_W-1:0] u, v);
        send_request(REQ_EVAL, 2'($urandom), 2'($urandom), rand_coord(), rand_coord(),
                     rand_coord(), u, v);
    endtask

    // whole grid in a scrambled order; fill: 0 random, 1 all max, 2 all min
    task automatic load_grid(input int fill);
        int start, stride, idx;
        start  = $urandom_range(0, 15);
        stride = 2 * $urandom_range(0, 7) + 1;
        for (int n = 0; n < 16; n++) begin
            idx = (start + n * stride) % 16;
            case (fill)
                1: load_point(idx, COORD_MAX, COORD_MAX, COORD_MAX);
                2: load_point(idx, COORD_MIN, COORD_MIN, COORD_MIN);
                default: load_point(idx, rand_coord(), rand_coord(), rand_coord());
            endcase
        end
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (patch_expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_corners();
        for (int idx = 0; idx < 16; idx++)
            load_point(idx, idx[0] ? COORD_MIN : COORD_MAX, COORD_WIDTH'(idx * 16'h0811),
                       idx < 8 ? '0 : (idx[0] ? COORD_MAX : COORD_MIN));
        evaluate_at('0, '0);
        evaluate_at(PONE, PONE);
        evaluate_at('0, PONE);
        evaluate_at(PONE, '0);
        evaluate_at(PONE >> 1, PONE >> 1);
        evaluate_at({WT_W{1'b1}}, WT_W'(PONE + 1));   // above one, clamped
        evaluate_at(WT_W'(1), WT_W'(PONE - 1));
    endtask

    task automatic test_saturation();
        load_grid(1);
        repeat (12) evaluate_at(WT_W'($urandom_range(0, int'(PONE))),
                                WT_W'($urandom_range(0, int'(PONE))));
        load_grid(2);
        repeat (12) evaluate_at(WT_W'($urandom_range(0, int'(PONE))),
                                WT_W'($urandom_range(0, int'(PONE))));
    endtask

    // back-to-back evaluates, then the sender holds off until all results are in, then more evaluates around a load
    task automatic test_burst_and_drain();
        no_gaps = 1'b1;
        repeat (8) evaluate_at(rand_param(), rand_param());
        wait_results_drained();
        repeat (4) evaluate_at(rand_param(), rand_param());
        load_point($urandom_range(0, 15), rand_coord(), rand_coord(), rand_coord());
        evaluate_at(rand_param(), rand_param());
        no_gaps = 1'b0;
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 14; phase++) begin
            no_gaps = (phase % 4 == 3);
            load_grid(0);
            repeat (90) begin
                if ($urandom_range(0, 9) < 2)
                    load_point($urandom_range(0, 15), rand_coord(), rand_coord(), rand_coord());
                else
                    evaluate_at(rand_param(), rand_param());
            end
        end
        no_gaps = 1'b0;
    endtask

    // result side: random back-pressure and comparison
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b1;
            ready_hold    <= 0;
        end else if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (patch_expected_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_axis_tdata);
            end else begin
                t_surf exp_pt;
                exp_pt = patch_expected_q.pop_front();
                for (int k = 0; k < 3; k++)
                    if (m_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH] !== exp_pt[k]) begin
                        fail_count++;
                        $display("%0t: %s expected %0d actual %0d", $time, axis_name[k],
                                 $signed(exp_pt[k]),
                                 $signed(m_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH]));
                    end
            end
            if (!no_gaps) begin
                hold_draw = $urandom_range(0, 3);
                if (hold_draw > 0) begin
                    m_axis_tready <= 1'b0;
                    ready_hold    <= hold_draw - 1;
                end
            end
        end else if (!m_axis_tready) begin
            if (ready_hold == 0)
                m_axis_tready <= 1'b1;
            else
                ready_hold <= ready_hold - 1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("bicubic_bezier_patch_eval: mismatch");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 16; i++)
            for (int k = 0; k < 3; k++)
                ctrl_store[i][k] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_corners();
        test_saturation();
        test_burst_and_drain();
        test_random_mix();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("bicubic_bezier_patch_eval: match");
        else
            $display("bicubic_bezier_patch_eval: mismatch");
        $finish;
    end

endmodule
